@@ hdl/lkvc_pkg.sv @@
package lkvc_pkg;

	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 5;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SWEEP,
		ST_EMIT
	} lkvc_state_t;

	typedef struct packed {
		logic load;    // capture the input item and start the search scan
		logic scan;    // issue entry reads and process returned entries
		logic sweep;   // scan is the rank update pass, not the search
		logic decide;  // pick the target slot, apply eviction
		logic emit;    // load the result register
	} lkvc_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic lookup;
		logic out_free;
	} lkvc_status_t;

endpackage

@@ hdl/lkvc_ctrl.sv @@
module lkvc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lkvc_pkg::lkvc_status_t stat,
	output lkvc_pkg::lkvc_cmd_t    cmd
);
	import lkvc_pkg::*;

	lkvc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (stat.scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = stat.lookup ? ST_EMIT : ST_SWEEP;
			end
			ST_SWEEP: begin
				if (stat.scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SEARCH: begin
				cmd.scan = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			ST_SWEEP: begin
				cmd.scan  = 1'b1;
				cmd.sweep = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ hdl/lkvc_datapath.sv @@
module lkvc_datapath #(
	parameter int ENTRIES   = 16,
	parameter int DATA_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lkvc_pkg::lkvc_cmd_t                 cmd,
	output lkvc_pkg::lkvc_status_t              stat,
	input  logic                                opcode,
	input  logic [lkvc_pkg::KEY_BITS-1:0]       key,
	input  logic [lkvc_pkg::VALUE_BITS-1:0]     value,
	input  logic                                cfg_valid,
	input  logic [lkvc_pkg::CAP_BITS-1:0]       cfg_data,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                hit,
	output logic [lkvc_pkg::VALUE_BITS-1:0]     data,
	output logic                                evicted,
	output logic [lkvc_pkg::KEY_BITS-1:0]       evicted_key
);
	import lkvc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);
	localparam int CW = (UW > CAP_BITS) ? UW : CAP_BITS;
	localparam int VB = (DATA_BITS < VALUE_BITS) ? DATA_BITS : VALUE_BITS;
	localparam int MW = KEY_BITS + VB + IW;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	// entry memory: {key, value, rank}
	logic [MW-1:0]       mem_q [ENTRIES];
	logic [MW-1:0]       rd_data_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic                rd_vld_s1;

	logic [CAP_BITS-1:0] cap_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [UW-1:0]       used_q;
	logic [IW-1:0]       cnt_q;
	logic                issue_q;

	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VB-1:0]       val_q;
	logic                found_q;
	logic [IW-1:0]       found_idx_q;
	logic [IW-1:0]       found_rank_q;
	logic [VB-1:0]       found_val_q;
	logic                lru_any_q;
	logic [IW-1:0]       lru_idx_q;
	logic [IW-1:0]       lru_rank_q;
	logic [KEY_BITS-1:0] lru_key_q;
	logic                free_any_q;
	logic [IW-1:0]       free_idx_q;
	logic [IW-1:0]       target_q;
	logic                evict_q;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] data_q;
	logic                  evicted_q;
	logic [KEY_BITS-1:0]   evicted_key_q;

	logic                re;
	logic                we;
	logic [MW-1:0]       wd;
	logic [KEY_BITS-1:0] rd_key;
	logic [VB-1:0]       rd_val;
	logic [IW-1:0]       rd_rank;
	logic                ent_valid;
	logic [CAP_BITS-1:0] cap_eff;
	logic                full;
	logic                miss_insert;
	logic [IW-1:0]       target_d;

	assign rd_key    = rd_data_s1[MW-1 -: KEY_BITS];
	assign rd_val    = rd_data_s1[IW +: VB];
	assign rd_rank   = rd_data_s1[IW-1:0];
	assign ent_valid = valid_q[rd_idx_s1];
	assign re        = cmd.scan && issue_q;

	assign cap_eff     = (cap_q == '0) ? CAP_BITS'(1) : cap_q;
	assign full        = (CW'(used_q) >= CW'(cap_eff)) || (used_q == UW'(ENTRIES));
	assign miss_insert = (op_q == OP_INSERT) && !found_q;
	assign target_d    = miss_insert ? (full ? lru_idx_q : free_idx_q) : found_idx_q;

	// rank update pass: target gets rank 0, the others that it passes move back one
	always_comb begin
		we = 1'b0;
		wd = {key_q, val_q, IW'(0)};
		if (cmd.sweep && rd_vld_s1) begin
			if (rd_idx_s1 == target_q) begin
				we = 1'b1;
			end else if (ent_valid && (!found_q || rd_rank < found_rank_q)) begin
				we = 1'b1;
				wd = {rd_key, rd_val, IW'(rd_rank + IW'(1))};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[rd_idx_s1] <= wd;
		if (re) rd_data_s1 <= mem_q[cnt_q];
		rd_idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			valid_q     <= '0;
			used_q      <= '0;
			cnt_q       <= '0;
			issue_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) cap_q <= cfg_data;
			rd_vld_s1 <= re;
			if (cmd.decide && op_q == OP_INSERT) begin
				// an evicted slot is reused in place, so its valid bit stays set
				valid_q[target_d] <= 1'b1;
				if (miss_insert && !full) used_q <= used_q + UW'(1);
			end
			if (cmd.load || (cmd.decide && op_q == OP_INSERT)) begin
				cnt_q   <= '0;
				issue_q <= 1'b1;
			end else if (re) begin
				cnt_q <= cnt_q + IW'(1);
				if (cnt_q == LAST) issue_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= opcode;
			key_q      <= key;
			val_q      <= value[VB-1:0];
			found_q    <= 1'b0;
			lru_any_q  <= 1'b0;
			free_any_q <= 1'b0;
		end else if (cmd.scan && !cmd.sweep && rd_vld_s1) begin
			if (ent_valid && rd_key == key_q) begin
				found_q      <= 1'b1;
				found_idx_q  <= rd_idx_s1;
				found_rank_q <= rd_rank;
				found_val_q  <= rd_val;
			end
			if (ent_valid && (!lru_any_q || rd_rank > lru_rank_q)) begin
				lru_any_q  <= 1'b1;
				lru_idx_q  <= rd_idx_s1;
				lru_rank_q <= rd_rank;
				lru_key_q  <= rd_key;
			end
			if (!ent_valid && !free_any_q) begin
				free_any_q <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
		end
		if (cmd.load) begin
			evict_q <= 1'b0;
		end else if (cmd.decide) begin
			target_q <= target_d;
			evict_q  <= miss_insert && full;
		end
		if (cmd.emit) begin
			hit_q         <= found_q;
			data_q        <= (op_q == OP_LOOKUP && found_q) ? VALUE_BITS'(found_val_q) : '0;
			evicted_q     <= evict_q;
			evicted_key_q <= evict_q ? lru_key_q : '0;
		end
	end

	assign stat.scan_done = rd_vld_s1 && (rd_idx_s1 == LAST);
	assign stat.lookup    = (op_q == OP_LOOKUP);
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign data        = data_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

@@ hdl/lru_key_value_cache.sv @@
// Fully associative key/value cache with least-recently-used replacement, ENTRIES
// entries of a 64-bit key and a value masked to DATA_BITS. One item is in work at a
// time. The entry memory is single-port; it is scanned one entry per cycle to search
// and, for an insert, once more to rewrite the recency ranks, which a lookup skips.
// The next item is taken while a finished result still waits in the output register.
// capacity_in_use is written on the cfg channel (always ready); the user must write it
// only while the block is idle, as the block itself does not enforce this.
module lru_key_value_cache #(
	parameter int ENTRIES   = 16,
	parameter int DATA_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [31:0] data,
	output logic        evicted,
	output logic [63:0] evicted_key,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);
	import lkvc_pkg::*;

	lkvc_cmd_t    cmd;
	lkvc_status_t stat;

	assign cfg_ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lkvc_datapath #(
		.ENTRIES   (ENTRIES),
		.DATA_BITS (DATA_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.key         (key),
		.value       (value),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.hit         (hit),
		.data        (data),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

@@ hdl/lkvc_checker.sv @@
module lkvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        opcode,
	input logic [63:0] key,
	input logic [31:0] value,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [31:0] data,
	input logic        evicted,
	input logic [63:0] evicted_key,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [4:0]  cfg_data
);

	// one item in work at a time: a transfer in closes the input until it is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(data)
			&& $stable(evicted) && $stable(evicted_key)))
		else $error("stalled result changed");

	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evicted) |-> !hit)
		else $error("eviction reported on a hit");

	a_data_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (data != 32'd0)) |-> (hit && !evicted))
		else $error("data returned without a lookup hit");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evicted) |-> (evicted_key == 64'd0))
		else $error("evicted key set without eviction");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
